FILE: rtl/core/csp_pkg.sv
// shared types and constants of the comma separated decimal parser
package csp_pkg;

   // character codes
   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_BANG     = 8'h21;
   localparam logic [7:0] CH_COMMA    = 8'h2C;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_DIGIT_LO = 8'h30;
   localparam logic [7:0] CH_DIGIT_HI = 8'h39;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_COUNT     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_LIMIT = 4'd1;
   localparam logic [3:0] SKIP_COUNT_RESET     = 4'd2;
   localparam logic [7:0] POSITION_LIMIT_RESET = 8'd16;

   // field words are handled one nibble per cycle
   localparam int VALUE_W   = 32;
   localparam int NIBBLES   = VALUE_W / 4;
   localparam int NIB_CNT_W = $clog2(NIBBLES);

   typedef enum logic {
      OP_MAC,   // acc = acc * 10 + digit
      OP_XFER   // stream the signed field out, leaving acc at zero
   } acc_op_type;

   typedef struct packed {
      logic       start;
      logic       clear;
      acc_op_type op;
      logic       negate;
      logic [3:0] digit;
   } acc_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic shift;
   } acc_sts_type;

endpackage

FILE: rtl/core/csp_if.sv
// valid/ready channel interfaces of the parser

// character input channel
interface csp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

// parsed field result channel
interface csp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         field_index;
   logic [2:0]         field_count;
   logic               last;
   modport source (output valid, output value, output field_index, output field_count,
                   output last, input ready);
   modport sink   (input valid, input value, input field_index, input field_count,
                   input last, output ready);
endinterface

// register write channel
interface csp_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/csp_serial_acc.sv
// nibble-serial accumulator: multiply by ten and add, or stream out the signed field
module csp_serial_acc (
   input  logic                  clock,
   input  logic                  reset,
   input  csp_pkg::acc_ctl_type  ctl,
   output logic [3:0]            out_nib,
   output csp_pkg::acc_sts_type  sts
);
   import csp_pkg::*;

   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic [NIB_CNT_W-1:0] cnt_ff, cnt_in;
   logic [3:0]           carry_ff, carry_in;
   logic                 busy_ff, busy_in;
   acc_op_type           op_ff, op_in;
   logic [3:0]           nib_sel;
   logic [7:0]           prod;
   logic [7:0]           sum;
   logic                 last_nib;

   // one nibble of the word per cycle, lowest first
   always_comb begin
      nib_sel  = ctl.negate ? ~acc_ff[3:0] : acc_ff[3:0];
      prod     = (op_ff == OP_MAC) ? ({4'b0, acc_ff[3:0]} * 8'd10) : {4'b0, nib_sel};
      sum      = prod + {4'b0, carry_ff};
      out_nib  = sum[3:0];
      last_nib = (cnt_ff == NIB_CNT_W'(NIBBLES - 1));
   end

   // next state
   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      carry_in = carry_ff;
      busy_in  = busy_ff;
      op_in    = op_ff;
      if (busy_ff) begin
         // rotate: mac writes the new nibble back, transfer drains to zero
         acc_in   = {((op_ff == OP_MAC) ? sum[3:0] : 4'b0), acc_ff[VALUE_W-1:4]};
         carry_in = sum[7:4];
         cnt_in   = cnt_ff + 1'b1;
         if (last_nib) begin
            busy_in = 1'b0;
         end
      end else if (ctl.start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         op_in    = ctl.op;
         carry_in = (ctl.op == OP_MAC) ? ctl.digit : {3'b0, ctl.negate};
      end else if (ctl.clear) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         carry_ff <= '0;
         busy_ff  <= 1'b0;
         op_ff    <= OP_MAC;
      end else begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         carry_ff <= carry_in;
         busy_ff  <= busy_in;
         op_ff    <= op_in;
      end
   end

   // status back to the sequencer
   always_comb begin
      sts.busy  = busy_ff;
      sts.done  = busy_ff && last_nib;
      sts.shift = busy_ff && (op_ff == OP_XFER);
   end

endmodule

FILE: rtl/core/csp_field_store.sv
// stored field words, each filled one nibble per cycle from the accumulator
module csp_field_store #(
   parameter int MAX_FIELDS = 4,
   parameter int IDX_W      = 2
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_sel,
   input  logic [3:0]                  wr_nib,
   input  logic [IDX_W-1:0]            rd_sel,
   output logic [csp_pkg::VALUE_W-1:0] rd_data
);
   import csp_pkg::*;

   logic [VALUE_W-1:0] entry_ff [MAX_FIELDS];

   // shift the selected entry right by one nibble
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_sel] <= {wr_nib, entry_ff[wr_sel][VALUE_W-1:4]};
      end
   end

   // read port for the drain
   assign rd_data = entry_ff[rd_sel];

endmodule

FILE: rtl/core/csv_signed_decimal_parser.sv
// top level: comma separated signed decimal parser
//
// Characters arrive one per beat on req_if; parsed fields leave on rsp_if as
// a run of beats carrying value, field_index, field_count and last. Register
// writes on csr_if (index 0 skip_count, index 1 position_limit) are always
// ready and are meant to be issued while no message is in flight.
// Per character: a digit, or a comma that stores a field, runs the 32-bit
// accumulator one nibble per cycle through a shared multiply-by-ten adder;
// a skipped or dropped character and every other character is handled in
// the idle state. A terminator of a good message stores its last field the
// same way, then the run is drained at one beat per cycle while the receiver
// is ready. An invalid message or a position limit overrun gives one beat
// with field_count zero, loaded into the output register from the emit state
// once that register is free.
// req_if.ready is high only while the sequencer is idle; a finished beat
// waits in the output register while the next character is taken.
// Reset restores skip_count 2 and position_limit 16 and clears message state.
// When the receiver stalls, the pending beat holds and the drain pauses.
module csv_signed_decimal_parser #(
   parameter int MAX_FIELDS = 4
) (
   input  logic clock,
   input  logic reset,
   csp_req_if.sink   req_if,
   csp_rsp_if.source rsp_if,
   csp_csr_if.sink   csr_if
);
   import csp_pkg::*;

   localparam int IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT, ST_DRAIN} state_type;
   typedef enum logic [1:0] {POST_NONE, POST_FIELD, POST_TERM} post_type;

   state_type          state_ff, state_in;
   post_type           post_ff, post_in;
   logic [3:0]         skip_ff, skip_in;
   logic [7:0]         limit_ff, limit_in;
   logic [7:0]         pos_ff, pos_in;
   logic [IDX_W-1:0]   fc_ff, fc_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic               neg_ff, neg_in;
   logic               disc_ff, disc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]         rsp_index_ff, rsp_index_in;
   logic [2:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   acc_ctl_type        acc_ctl;
   acc_sts_type        acc_sts;
   logic [3:0]         acc_nib;
   logic [VALUE_W-1:0] store_rd;

   logic       req_acc;
   logic       csr_acc;
   logic [7:0] ch;
   logic       is_term;
   logic       is_digit;
   logic       in_skip;
   logic       lim_hit;
   logic       has_room;
   logic       rsp_free;
   logic       rsp_load;
   logic       drain_last;
   logic [IDX_W:0] count_full;

   csp_serial_acc u_acc (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .out_nib (acc_nib),
      .sts     (acc_sts)
   );

   csp_field_store #(
      .MAX_FIELDS (MAX_FIELDS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (acc_sts.shift),
      .wr_sel  (fc_ff),
      .wr_nib  (acc_nib),
      .rd_sel  (idx_ff),
      .rd_data (store_rd)
   );

   // handshakes and character classes
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      csr_if.ready = 1'b1;
      req_acc      = req_if.valid && req_if.ready;
      csr_acc      = csr_if.valid && csr_if.ready;
      ch           = req_if.ch;
      is_term      = (ch == CH_NUL) || (ch == CH_BANG);
      is_digit     = (ch >= CH_DIGIT_LO) && (ch <= CH_DIGIT_HI);
      in_skip      = (pos_ff < {4'b0, skip_ff});
      lim_hit      = (({1'b0, pos_ff} + 9'd1) > {1'b0, limit_ff});
      has_room     = (fc_ff != IDX_W'(MAX_FIELDS - 1));
      rsp_free     = !rsp_valid_ff || rsp_if.ready;
      drain_last   = (idx_ff == fc_ff);
      count_full   = {1'b0, fc_ff} + 1'b1;
   end

   // message sequencer
   always_comb begin
      state_in     = state_ff;
      post_in      = post_ff;
      skip_in      = skip_ff;
      limit_in     = limit_ff;
      pos_in       = pos_ff;
      fc_in        = fc_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      neg_in       = neg_ff;
      disc_in      = disc_ff;
      rsp_load     = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      acc_ctl        = '0;
      acc_ctl.op     = OP_MAC;
      acc_ctl.negate = neg_ff;
      acc_ctl.digit  = ch[3:0];

      // register writes
      if (csr_acc) begin
         case (csr_if.index)
            CSR_SKIP_COUNT:     skip_in  = csr_if.data[3:0];
            CSR_POSITION_LIMIT: limit_in = csr_if.data;
            default:            ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (disc_ff) begin
                  // drop everything up to and including a terminator
                  if (is_term) begin
                     disc_in = 1'b0;
                  end
               end else if (in_skip) begin
                  pos_in = pos_ff + 8'd1;
               end else if (is_term) begin
                  if (!valid_ff) begin
                     state_in      = ST_EMIT;
                     acc_ctl.clear = 1'b1;
                     neg_in        = 1'b0;
                     fc_in         = '0;
                     pos_in        = '0;
                     valid_in      = 1'b1;
                  end else begin
                     state_in      = ST_RUN;
                     post_in       = POST_TERM;
                     acc_ctl.start = 1'b1;
                     acc_ctl.op    = OP_XFER;
                  end
               end else if (lim_hit) begin
                  // overrun: report at once, then discard
                  state_in      = ST_EMIT;
                  acc_ctl.clear = 1'b1;
                  neg_in        = 1'b0;
                  fc_in         = '0;
                  pos_in        = '0;
                  valid_in      = 1'b1;
                  disc_in       = 1'b1;
               end else begin
                  pos_in = pos_ff + 8'd1;
                  if (ch == CH_COMMA) begin
                     if (has_room) begin
                        state_in      = ST_RUN;
                        post_in       = POST_FIELD;
                        acc_ctl.start = 1'b1;
                        acc_ctl.op    = OP_XFER;
                     end else begin
                        valid_in      = 1'b0;
                        neg_in        = 1'b0;
                        acc_ctl.clear = 1'b1;
                     end
                  end else if (ch == CH_MINUS) begin
                     neg_in = 1'b1;
                  end else if ((ch == CH_CR) || (ch == CH_LF)) begin
                     neg_in = neg_ff;
                  end else if (is_digit) begin
                     state_in      = ST_RUN;
                     post_in       = POST_NONE;
                     acc_ctl.start = 1'b1;
                     acc_ctl.op    = OP_MAC;
                  end else begin
                     valid_in = 1'b0;
                  end
               end
            end
         end

         ST_RUN: begin
            if (acc_sts.done) begin
               case (post_ff)
                  POST_FIELD: begin
                     fc_in    = fc_ff + 1'b1;
                     neg_in   = 1'b0;
                     state_in = ST_IDLE;
                  end
                  POST_TERM: begin
                     neg_in   = 1'b0;
                     idx_in   = '0;
                     state_in = ST_DRAIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = '0;
               rsp_index_in = '0;
               rsp_count_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_DRAIN: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = store_rd;
               rsp_index_in = 2'(idx_ff);
               rsp_count_in = 3'(count_full);
               rsp_last_in  = drain_last;
               if (drain_last) begin
                  fc_in    = '0;
                  pos_in   = '0;
                  valid_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register valid
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         post_ff      <= POST_NONE;
         skip_ff      <= SKIP_COUNT_RESET;
         limit_ff     <= POSITION_LIMIT_RESET;
         pos_ff       <= '0;
         fc_ff        <= '0;
         idx_ff       <= '0;
         valid_ff     <= 1'b1;
         neg_ff       <= 1'b0;
         disc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         post_ff      <= post_in;
         skip_ff      <= skip_in;
         limit_ff     <= limit_in;
         pos_ff       <= pos_in;
         fc_ff        <= fc_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         neg_ff       <= neg_in;
         disc_ff      <= disc_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_value_ff <= rsp_value_in;
         rsp_index_ff <= rsp_index_in;
         rsp_count_ff <= rsp_count_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // result port
   always_comb begin
      rsp_if.valid       = rsp_valid_ff;
      rsp_if.value       = rsp_value_ff;
      rsp_if.field_index = rsp_index_ff;
      rsp_if.field_count = rsp_count_ff;
      rsp_if.last        = rsp_last_ff;
   end

   // field counter never passes the last store entry
   assert property (@(posedge clock) disable iff (reset)
      fc_ff <= IDX_W'(MAX_FIELDS - 1))
      else $error("field counter beyond store");

   // the serial unit only works while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      acc_sts.busy |-> (state_ff == ST_RUN))
      else $error("serial unit busy outside run state");

   // an invalid beat always closes its run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_count_ff == 3'd0) && (rsp_index_ff == 2'd0)
       && (MAX_FIELDS < 8)) |-> rsp_last_ff)
      else $error("count zero beat without last");

   // last drained beat ends the message
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && rsp_load && drain_last) |=>
      ((state_ff == ST_IDLE) && (fc_ff == '0) && (pos_ff == 8'd0)))
      else $error("drain did not restart message");

   // discarding starts from a cleared message
   assert property (@(posedge clock) disable iff (reset)
      disc_ff |-> ((fc_ff == '0) && !neg_ff && valid_ff))
      else $error("discard with stale message state");

endmodule
